>>> hdl/assert_macros.svh
// Assertion macros shared by the line point generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LPG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("line point generator: assertion failed");

// Check that a condition never holds outside reset.
`define LPG_ASSERT_NEVER(label, clk, rst_n, cond) \
    `LPG_ASSERT(label, clk, rst_n, !(cond))

`endif

>>> hdl/lpg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the line point generator.
package lpg_pkg;

    localparam int COORD_BITS = 6;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int MODE_BITS  = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam logic [QCNT_BITS-1:0] QDEPTH_CNT = QCNT_BITS'(QDEPTH);

    typedef logic [COORD_BITS-1:0]       t_coord;
    typedef logic signed [ERR_BITS-1:0]  t_err;
    typedef logic [MODE_BITS-1:0]        t_mode;

    // Classified line request, as it travels from front to walker.
    typedef struct packed {
        t_coord maj;
        t_coord mnr;
        logic   maj_neg;
        logic   mnr_neg;
        logic   steep;
        t_coord dmaj;
        t_coord dmnr;
        t_err   err;
        t_coord end_x;
        t_coord end_y;
        t_mode  mode;
    } t_cmd;

    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
        logic                 full;
        logic                 empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_WALK,
        WS_END
    } t_walk_state;

    typedef struct packed {
        t_walk_state state;
        t_coord      cnt;
    } t_walk_stat;

    // Move a coordinate one unit up or down.
    function automatic t_coord step_coord(input t_coord v, input logic neg);
        return neg ? (v - t_coord'(1)) : (v + t_coord'(1));
    endfunction

endpackage

>>> hdl/lpg_front.sv
`timescale 1ns / 1ps
// Front stage: accepts line requests, picks the major axis and the start error.
module lpg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lpg_pkg::t_coord     i_start_x,
    input  lpg_pkg::t_coord     i_start_y,
    input  lpg_pkg::t_coord     i_end_x,
    input  lpg_pkg::t_coord     i_end_y,
    input  lpg_pkg::t_mode      i_draw_mode,
    input  logic                i_full,
    output logic                o_push,
    output lpg_pkg::t_cmd       o_cmd
);

    logic            r_vld;
    logic            n_vld;
    lpg_pkg::t_cmd   r_cmd;
    lpg_pkg::t_cmd   n_cmd;

    lpg_pkg::t_coord dx;
    lpg_pkg::t_coord dy;
    logic            x_pos;
    logic            y_pos;
    logic            steep;
    logic            take;

    always_comb begin
        x_pos = i_end_x > i_start_x;
        y_pos = i_end_y > i_start_y;
        dx    = x_pos ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
        dy    = y_pos ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
        steep = dy > dx;

        n_cmd.steep   = steep;
        n_cmd.maj     = steep ? i_start_y : i_start_x;
        n_cmd.mnr     = steep ? i_start_x : i_start_y;
        n_cmd.maj_neg = steep ? !y_pos : !x_pos;
        n_cmd.mnr_neg = steep ? !x_pos : !y_pos;
        n_cmd.dmaj    = steep ? dy : dx;
        n_cmd.dmnr    = steep ? dx : dy;
        // start error: 2*minor - major
        n_cmd.err     = lpg_pkg::t_err'({2'b00, n_cmd.dmnr, 1'b0})
                      - lpg_pkg::t_err'({3'b000, n_cmd.dmaj});
        n_cmd.end_x   = i_end_x;
        n_cmd.end_y   = i_end_y;
        n_cmd.mode    = i_draw_mode;
    end

    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;
    assign take    = i_valid && o_ready;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_vld = r_vld;
        if (take) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> hdl/lpg_queue.sv
`timescale 1ns / 1ps
// Short request queue between the front stage and the walker.
module lpg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpg_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output lpg_pkg::t_cmd     o_cmd,
    output lpg_pkg::t_q_stat  o_stat
);

    lpg_pkg::t_cmd                   r_mem [lpg_pkg::QDEPTH];
    logic [lpg_pkg::QPTR_BITS-1:0]   r_wr;
    logic [lpg_pkg::QPTR_BITS-1:0]   r_rd;
    logic [lpg_pkg::QCNT_BITS-1:0]   r_count;
    logic [lpg_pkg::QPTR_BITS-1:0]   n_wr;
    logic [lpg_pkg::QPTR_BITS-1:0]   n_rd;
    logic [lpg_pkg::QCNT_BITS-1:0]   n_count;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [lpg_pkg::QPTR_BITS-1:0] LastPtr =
        lpg_pkg::QPTR_BITS'(lpg_pkg::QDEPTH - 1);

    assign o_stat.count = r_count;
    assign o_stat.full  = r_count == lpg_pkg::QDEPTH_CNT;
    assign o_stat.empty = r_count == '0;
    assign o_cmd        = r_mem[r_rd];

    // drop requests that would overrun or underrun
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hdl/lpg_walker.sv
`timescale 1ns / 1ps
// Back stage: walks one line request and emits one point per cycle while i_ready takes them.
module lpg_walker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  lpg_pkg::t_cmd        i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lpg_pkg::t_coord      o_pixel_x,
    output lpg_pkg::t_coord      o_pixel_y,
    output lpg_pkg::t_mode       o_mode_out,
    output logic                 o_last_point,
    output lpg_pkg::t_walk_stat  o_stat
);

    lpg_pkg::t_walk_state r_state;
    lpg_pkg::t_walk_state n_state;
    lpg_pkg::t_cmd        r_cmd;
    lpg_pkg::t_cmd        n_cmd;
    lpg_pkg::t_coord      r_maj;
    lpg_pkg::t_coord      n_maj;
    lpg_pkg::t_coord      r_mnr;
    lpg_pkg::t_coord      n_mnr;
    lpg_pkg::t_err        r_err;
    lpg_pkg::t_err        n_err;
    lpg_pkg::t_coord      r_cnt;
    lpg_pkg::t_coord      n_cnt;
    logic                 r_out_vld;
    logic                 n_out_vld;
    lpg_pkg::t_coord      r_px;
    lpg_pkg::t_coord      n_px;
    lpg_pkg::t_coord      r_py;
    lpg_pkg::t_coord      n_py;
    lpg_pkg::t_mode       r_mode;
    lpg_pkg::t_mode       n_mode;
    logic                 r_last;
    logic                 n_last;

    logic                 slot;
    logic                 err_ge0;
    lpg_pkg::t_err        two_maj;
    lpg_pkg::t_err        two_mnr;
    lpg_pkg::t_err        err_m;

    assign slot    = !r_out_vld || i_ready;
    assign err_ge0 = !r_err[lpg_pkg::ERR_BITS-1];
    assign two_maj = lpg_pkg::t_err'({2'b00, r_cmd.dmaj, 1'b0});
    assign two_mnr = lpg_pkg::t_err'({2'b00, r_cmd.dmnr, 1'b0});
    assign err_m   = err_ge0 ? (r_err - two_maj) : r_err;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_maj     = r_maj;
        n_mnr     = r_mnr;
        n_err     = r_err;
        n_cnt     = r_cnt;
        n_px      = r_px;
        n_py      = r_py;
        n_mode    = r_mode;
        n_last    = r_last;
        n_out_vld = r_out_vld && !i_ready;
        o_pop     = 1'b0;
        case (r_state)
            lpg_pkg::WS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_maj   = i_cmd.maj;
                    n_mnr   = i_cmd.mnr;
                    n_err   = i_cmd.err;
                    n_cnt   = i_cmd.dmaj;
                    n_state = (i_cmd.dmaj == '0) ? lpg_pkg::WS_END : lpg_pkg::WS_WALK;
                end
            end
            lpg_pkg::WS_WALK: begin
                if (slot) begin
                    n_out_vld = 1'b1;
                    n_px      = r_cmd.steep ? r_mnr : r_maj;
                    n_py      = r_cmd.steep ? r_maj : r_mnr;
                    n_mode    = r_cmd.mode;
                    n_last    = 1'b0;
                    // a non-negative error takes one minor step
                    if (err_ge0) begin
                        n_mnr = lpg_pkg::step_coord(r_mnr, r_cmd.mnr_neg);
                    end
                    n_maj = lpg_pkg::step_coord(r_maj, r_cmd.maj_neg);
                    n_err = err_m + two_mnr;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == lpg_pkg::t_coord'(1)) begin
                        n_state = lpg_pkg::WS_END;
                    end
                end
            end
            lpg_pkg::WS_END: begin
                if (slot) begin
                    n_out_vld = 1'b1;
                    n_px      = r_cmd.end_x;
                    n_py      = r_cmd.end_y;
                    n_mode    = r_cmd.mode;
                    n_last    = 1'b1;
                    n_state   = lpg_pkg::WS_IDLE;
                end
            end
            default: begin
                n_state = lpg_pkg::WS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lpg_pkg::WS_IDLE;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_maj  <= n_maj;
        r_mnr  <= n_mnr;
        r_err  <= n_err;
        r_px   <= n_px;
        r_py   <= n_py;
        r_mode <= n_mode;
        r_last <= n_last;
    end

    assign o_valid      = r_out_vld;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_mode_out   = r_mode;
    assign o_last_point = r_last;
    assign o_stat.state = r_state;
    assign o_stat.cnt   = r_cnt;

endmodule

>>> hdl/line_point_generator_core.sv
`timescale 1ns / 1ps
// Top level of the line point generator: front stage, request queue, walker.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_start_x i_start_y i_end_x i_end_y i_draw_mode
//  point     out        o_valid / i_ready   o_pixel_x o_pixel_y o_mode_out o_last_point
//
// A line of major length d gives d+1 points, one per cycle while o_valid is taken,
// after a load step in which the walker takes the request from the queue.
// The walker's one-point-per-step loop sets the request rate; the front stage and a
// two-deep queue let later requests be taken while a line is still being walked.
// Reset (i_rst_n low, synchronous) empties the queue and idles the walker.
// A stalled i_ready only pulls o_ready low once the queue and front register are full.
`include "assert_macros.svh"

module line_point_generator_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  lpg_pkg::t_coord        i_start_x,
    input  lpg_pkg::t_coord        i_start_y,
    input  lpg_pkg::t_coord        i_end_x,
    input  lpg_pkg::t_coord        i_end_y,
    input  lpg_pkg::t_mode         i_draw_mode,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lpg_pkg::t_coord        o_pixel_x,
    output lpg_pkg::t_coord        o_pixel_y,
    output lpg_pkg::t_mode         o_mode_out,
    output logic                   o_last_point
);

    logic                 f_push;
    lpg_pkg::t_cmd        f_cmd;
    lpg_pkg::t_cmd        q_cmd;
    lpg_pkg::t_q_stat     q_stat;
    logic                 w_pop;
    lpg_pkg::t_walk_stat  w_stat;

    lpg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_draw_mode (i_draw_mode),
        .i_full      (q_stat.full),
        .o_push      (f_push),
        .o_cmd       (f_cmd)
    );

    lpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (w_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    lpg_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_stat.empty),
        .i_cmd        (q_cmd),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_mode_out   (o_mode_out),
        .o_last_point (o_last_point),
        .o_stat       (w_stat)
    );

    `LPG_ASSERT(a_walk_cnt, i_clk, i_rst_n, (w_stat.state == lpg_pkg::WS_WALK) |-> (w_stat.cnt != '0))
    `LPG_ASSERT(a_q_bound, i_clk, i_rst_n, q_stat.count <= lpg_pkg::QDEPTH_CNT)
    `LPG_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && q_stat.empty)

endmodule

>>> tb/sv/tb_line_point_generator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_point_generator_core against a Bresenham predictor.
module tb_line_point_generator_core;

    typedef struct packed {
        lpg_pkg::t_coord x0;
        lpg_pkg::t_coord y0;
        lpg_pkg::t_coord x1;
        lpg_pkg::t_coord y1;
        lpg_pkg::t_mode  mode;
    } t_line_req;

    typedef struct packed {
        lpg_pkg::t_coord px;
        lpg_pkg::t_coord py;
        lpg_pkg::t_mode  mode;
        logic            last;
    } t_pixel;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    lpg_pkg::t_coord i_start_x = '0;
    lpg_pkg::t_coord i_start_y = '0;
    lpg_pkg::t_coord i_end_x = '0;
    lpg_pkg::t_coord i_end_y = '0;
    lpg_pkg::t_mode  i_draw_mode = '0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    lpg_pkg::t_coord o_pixel_x;
    lpg_pkg::t_coord o_pixel_y;
    lpg_pkg::t_mode  o_mode_out;
    logic            o_last_point;

    t_line_req line_queue[$];
    t_pixel    expected_pixels[$];
    t_line_req cur_req;
    logic      hold_rx = 1'b0;

    int lines_total = 0;
    int lines_accepted = 0;
    int points_checked = 0;
    int steep_lines = 0;
    int longest_line = 0;
    int in_stall_cycles = 0;
    int err_cnt = 0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_gap = 0;
    int rx_calm = 0;

    line_point_generator_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_draw_mode  (i_draw_mode),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_mode_out   (o_mode_out),
        .o_last_point (o_last_point)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Walk the line the way the block should and queue every point it must emit.
    task automatic trace_line(input t_line_req r);
        int     ax, ay, bx, by;
        int     dx, dy, maj, mnr, smaj, smnr, dmaj, dmnr, err;
        int     step_x, step_y;
        bit     steep;
        t_pixel p;
        ax = r.x0;
        ay = r.y0;
        bx = r.x1;
        by = r.y1;
        step_x = (bx - ax) > 0 ? 1 : -1;
        step_y = (by - ay) > 0 ? 1 : -1;
        dx = bx > ax ? bx - ax : ax - bx;
        dy = by > ay ? by - ay : ay - by;
        steep = dy > dx;
        maj  = steep ? ay : ax;
        mnr  = steep ? ax : ay;
        smaj = steep ? step_y : step_x;
        smnr = steep ? step_x : step_y;
        dmaj = steep ? dy : dx;
        dmnr = steep ? dx : dy;
        err  = 2 * dmnr - dmaj;
        p.mode = r.mode;
        p.last = 1'b0;
        for (int i = 0; i < dmaj; i++) begin
            p.px = steep ? lpg_pkg::t_coord'(mnr) : lpg_pkg::t_coord'(maj);
            p.py = steep ? lpg_pkg::t_coord'(maj) : lpg_pkg::t_coord'(mnr);
            expected_pixels.push_back(p);
            // a tie steps the minor axis
            while (err >= 0) begin
                mnr += smnr;
                err -= 2 * dmaj;
            end
            maj += smaj;
            err += 2 * dmnr;
        end
        p.px = r.x1;
        p.py = r.y1;
        p.last = 1'b1;
        expected_pixels.push_back(p);
        if (steep) steep_lines++;
        if (dmaj + 1 > longest_line) longest_line = dmaj + 1;
    endtask

    task automatic report_mismatch(input string what);
        if (err_cnt < 30) $display("[%0t] MISMATCH: %s", $time, what);
        err_cnt++;
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("point (%0d,%0d) with no line pending",
                                      o_pixel_x, o_pixel_y));
            return;
        end
        want = expected_pixels.pop_front();
        points_checked++;
        if (o_pixel_x !== want.px)
            report_mismatch($sformatf("pixel_x %0d, want %0d", o_pixel_x, want.px));
        if (o_pixel_y !== want.py)
            report_mismatch($sformatf("pixel_y %0d, want %0d", o_pixel_y, want.py));
        if (o_mode_out !== want.mode)
            report_mismatch($sformatf("mode_out %0d, want %0d", o_mode_out, want.mode));
        if (o_last_point !== want.last)
            report_mismatch($sformatf("last_point %0b, want %0b at (%0d,%0d)",
                                      o_last_point, want.last, want.px, want.py));
    endtask

    // Mostly back-to-back, some short gaps, a few long ones, and calm stretches.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic int near(input int c, input int d);
        int v;
        v = c + d;
        if (v < 0) v = 0;
        if (v > 63) v = 63;
        return v;
    endfunction

    task automatic add_line(input int x0, input int y0, input int x1, input int y1,
                            input int mode);
        t_line_req r;
        r.x0 = lpg_pkg::t_coord'(x0);
        r.y0 = lpg_pkg::t_coord'(y0);
        r.x1 = lpg_pkg::t_coord'(x1);
        r.y1 = lpg_pkg::t_coord'(y1);
        r.mode = lpg_pkg::t_mode'(mode);
        line_queue.push_back(r);
    endtask

    // Request driver: hold a request until taken, then idle a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                trace_line(cur_req);
                lines_accepted++;
            end
            if (i_valid && !o_ready) begin
                in_stall_cycles++;
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (line_queue.size() > 0) begin
                cur_req = line_queue.pop_front();
                i_start_x   <= cur_req.x0;
                i_start_y   <= cur_req.y0;
                i_end_x     <= cur_req.x1;
                i_end_y     <= cur_req.y1;
                i_draw_mode <= cur_req.mode;
                i_valid     <= 1'b1;
                tx_gap = pick_gap(tx_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Point monitor: check each taken point, then pick the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (o_valid && i_ready) check_pixel();
            if (hold_rx) begin
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                rx_gap = pick_gap(rx_calm);
            end
        end
    end

    // Hold off the receiver once so the queue fills and the request side backs up.
    initial begin
        while (lines_accepted < 40) @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (500) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #30_000_000;
        $display("line_point_generator_core verification failed");
        $finish;
    end

    initial begin
        int r, k, d, x0, y0, x1, y1;

        // single points, full diagonals, both directions on each axis, ties
        add_line(0, 0, 0, 0, 0);
        add_line(63, 63, 63, 63, 3);
        add_line(0, 0, 63, 63, 1);
        add_line(63, 63, 0, 0, 2);
        add_line(0, 63, 63, 0, 0);
        add_line(63, 0, 0, 63, 3);
        add_line(0, 10, 63, 10, 1);
        add_line(63, 20, 0, 20, 2);
        add_line(5, 0, 5, 63, 3);
        add_line(40, 63, 40, 0, 0);
        add_line(0, 0, 63, 1, 1);
        add_line(0, 0, 1, 63, 2);
        add_line(10, 10, 12, 11, 3);
        add_line(30, 30, 29, 32, 0);
        add_line(20, 20, 26, 17, 1);
        add_line(50, 5, 47, 40, 2);
        add_line(1, 1, 2, 2, 3);
        add_line(33, 33, 32, 33, 0);
        add_line(62, 1, 63, 0, 1);
        add_line(21, 42, 42, 21, 2);

        for (int n = 0; n < 360; n++) begin
            r  = $urandom_range(0, 99);
            x0 = $urandom_range(0, 63);
            y0 = $urandom_range(0, 63);
            if (r < 45) begin
                x1 = $urandom_range(0, 63);
                y1 = $urandom_range(0, 63);
            end else if (r < 80) begin
                x1 = near(x0, $urandom_range(0, 14) - 7);
                y1 = near(y0, $urandom_range(0, 14) - 7);
            end else if (r < 92) begin
                k = $urandom_range(0, 2);
                d = $urandom_range(0, 63);
                x1 = (k == 1) ? x0 : near(x0, $urandom_range(0, 1) ? d : -d);
                y1 = (k == 0) ? y0 : near(y0, $urandom_range(0, 1) ? d : -d);
            end else begin
                x0 = $urandom_range(0, 2) == 0 ? x0 : ($urandom_range(0, 1) ? 63 : 0);
                y0 = $urandom_range(0, 2) == 0 ? y0 : ($urandom_range(0, 1) ? 63 : 0);
                x1 = $urandom_range(0, 3) == 0 ? x0 : ($urandom_range(0, 1) ? 63 : 0);
                y1 = $urandom_range(0, 3) == 0 ? y0 : ($urandom_range(0, 1) ? 63 : 0);
            end
            add_line(x0, y0, x1, y1, $urandom_range(0, 3));
        end
        lines_total = line_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (lines_accepted != lines_total || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Run covered %0d lines (%0d steep), %0d points checked, longest %0d points.",
                 lines_accepted, steep_lines, points_checked, longest_line);
        $display("Request side was held back for %0d cycles by a full block.",
                 in_stall_cycles);
        if (err_cnt == 0) begin
            $display("line_point_generator_core verification clean");
        end else begin
            $display("line_point_generator_core verification failed");
        end
        $finish;
    end

endmodule
